@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active low).
`define RMTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion, checked also during reset.
`define RMTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/rmts_pkg.sv @@
// Types and constants of the rate-monotonic tick scheduler.
package rmts_pkg;

    localparam int TIME_W     = 32;
    localparam int WORD_W     = 16;
    localparam int OUT_TASK_W = 3;
    localparam int CFG_IDX_W  = 8;

    // Register map: periods first, then budgets, REG_SLOTS of each.
    localparam int REG_SLOTS       = 4;
    localparam int CFG_PERIOD_BASE = 0;
    localparam int CFG_BUDGET_BASE = REG_SLOTS;

    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [OUT_TASK_W-1:0] t_task;

endpackage

@@ rtl/rate_monotonic_tick_scheduler.sv @@
// Rate-monotonic tick scheduler: one scheduling decision per tick transaction.
//
// Input channel (i_in_valid / o_in_stall, i_now): one transaction per time tick,
// carrying the current time. Output channel (o_out_valid / i_out_stall):
// one transaction per input tick, naming the slot that ran (TASK_SLOTS = idle,
// masked to 3 bits) and whether its job finished its budget on that tick.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0..3 writes
// the periods, 4..7 the budgets; other indices are dropped. Write only while
// the block holds no tick in flight.
//
// Path from input transaction to result: input register, then result register.
// Throughput: one tick per cycle while the receiver does not stall; the release
// compares, the shortest-period pick over the slots and the used-time update all
// sit between the input register and the result register.
// When the receiver stalls, the result register holds, the input register
// still fills once, and o_in_stall rises only when both are occupied.
// Reset (synchronous, active low) clears all job state, periods to zero,
// budgets to one, and empties both registers.
module rate_monotonic_tick_scheduler #(
    parameter int TASK_SLOTS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rmts_pkg::t_time    i_now,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rmts_pkg::t_task    o_running_task,
    output logic               o_job_done,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  rmts_pkg::t_cfg_idx i_cfg_index,
    input  rmts_pkg::t_word    i_cfg_data
);
    import rmts_pkg::*;

    localparam int PICK_W = $clog2(TASK_SLOTS + 1);

    // configuration
    t_word r_period [TASK_SLOTS];
    t_word r_budget [TASK_SLOTS];

    // per-slot job state
    t_time r_next_release [TASK_SLOTS];
    logic  [TASK_SLOTS-1:0] r_pending;
    t_word r_used [TASK_SLOTS];

    t_time n_next_release [TASK_SLOTS];
    logic  [TASK_SLOTS-1:0] n_pending;
    t_word n_used [TASK_SLOTS];

    // input and result registers
    logic  r_in_valid;
    t_time r_now;
    logic  r_out_valid;
    t_task r_running_task;
    logic  r_job_done;

    logic               adv;
    logic [TASK_SLOTS-1:0] en;
    logic [TASK_SLOTS-1:0] rel;
    logic [TASK_SLOTS-1:0] pend1;
    logic [TASK_SLOTS-1:0] sel;
    logic [TASK_SLOTS-1:0] done_s;
    t_word              used_inc [TASK_SLOTS];
    t_word              bud_eff  [TASK_SLOTS];
    t_word              best;
    logic               found;
    logic [PICK_W-1:0]  pick;
    logic               n_done;

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_running_task = r_running_task;
    assign o_job_done  = r_job_done;
    assign o_cfg_ready = 1'b1;

    // release, then shortest-period pick (strict less: ties keep the lower slot)
    always_comb begin
        found = 1'b0;
        best  = '0;
        sel   = '0;
        pick  = PICK_W'(TASK_SLOTS);
        for (int s = 0; s < TASK_SLOTS; s++) begin
            en[s]    = (r_period[s] != '0);
            rel[s]   = en[s] && !r_pending[s] && (r_now >= r_next_release[s]);
            pend1[s] = r_pending[s] || rel[s];
            if (en[s] && pend1[s] && (!found || (r_period[s] < best))) begin
                found  = 1'b1;
                best   = r_period[s];
                sel    = '0;
                sel[s] = 1'b1;
                pick   = PICK_W'(s);
            end
        end
    end

    // execution of the picked job and next job state
    always_comb begin
        for (int s = 0; s < TASK_SLOTS; s++) begin
            used_inc[s] = r_used[s] + WORD_W'(1);
            bud_eff[s]  = (r_budget[s] == '0) ? WORD_W'(1) : r_budget[s];
            done_s[s]   = sel[s] && (used_inc[s] >= bud_eff[s]);
            n_next_release[s] = rel[s] ? (r_next_release[s] + TIME_W'(r_period[s]))
                                       : r_next_release[s];
            n_pending[s] = pend1[s] && !done_s[s];
            if (done_s[s]) begin
                n_used[s] = '0;
            end else if (sel[s]) begin
                n_used[s] = used_inc[s];
            end else begin
                n_used[s] = r_used[s];
            end
        end
        n_done = |done_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            for (int s = 0; s < TASK_SLOTS; s++) begin
                r_period[s]       <= '0;
                r_budget[s]       <= WORD_W'(1);
                r_next_release[s] <= '0;
                r_used[s]         <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_pending   <= n_pending;
                for (int s = 0; s < TASK_SLOTS; s++) begin
                    r_next_release[s] <= n_next_release[s];
                    r_used[s]         <= n_used[s];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                for (int s = 0; s < TASK_SLOTS; s++) begin
                    if (s < REG_SLOTS) begin
                        if (i_cfg_index == CFG_IDX_W'(CFG_PERIOD_BASE + s)) begin
                            r_period[s] <= i_cfg_data;
                        end
                        if (i_cfg_index == CFG_IDX_W'(CFG_BUDGET_BASE + s)) begin
                            r_budget[s] <= i_cfg_data;
                        end
                    end
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_now <= i_now;
        end
        if (adv) begin
            r_running_task <= OUT_TASK_W'(pick);
            r_job_done     <= n_done;
        end
    end

endmodule

@@ rtl/rmts_checker.sv @@
// Port-level checks of the rate-monotonic tick scheduler, bound to the top level.
`include "assert_macros.svh"

module rmts_checker #(
    parameter int TASK_SLOTS = 4
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [2:0]             o_running_task,
    input logic                   o_job_done
);
    import rmts_pkg::*;

    localparam int IDLE_CODE = TASK_SLOTS % (1 << OUT_TASK_W);

    `RMTS_ASSERT(a_task_range, i_clk, i_rst_n, o_out_valid |-> ((TASK_SLOTS >= 8) || (o_running_task <= OUT_TASK_W'(TASK_SLOTS))), "running_task beyond idle code")
    `RMTS_ASSERT(a_idle_not_done, i_clk, i_rst_n, (o_out_valid && (TASK_SLOTS < 8) && (o_running_task == OUT_TASK_W'(IDLE_CODE))) |-> !o_job_done, "job_done on an idle tick")
    `RMTS_ASSERT(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_out_valid, "result valid right after reset")
    `RMTS_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_running_task) && $stable(o_job_done)), "stalled result changed")

endmodule

bind rate_monotonic_tick_scheduler rmts_checker #(.TASK_SLOTS(TASK_SLOTS)) u_rmts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_running_task (o_running_task),
    .o_job_done     (o_job_done)
);
